/* hdl/skf_pkg.sv */
package skf_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEN,
    S_DIV,
    S_MUL_EST,
    S_MUL_COV,
    S_COV_WB,
    S_OUT
  } state_t;

  localparam int EST_W   = 32;  // estimate, signed Q16.16
  localparam int COV_W   = 32;  // error covariance, unsigned Q16.16
  localparam int NOISE_W = 31;  // Q and R registers
  localparam int PPRE_W  = 33;  // P + Q never wraps
  localparam int DEN_W   = 34;  // P + Q + R
  localparam int MULB_W  = 34;  // second multiplier operand, signed
  localparam int UPD_W   = 36;  // product after the fraction shift

  localparam logic [NOISE_W-1:0] Q_RESET = 31'd655;
  localparam logic [NOISE_W-1:0] R_RESET = 31'd65536;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 1'b1;

endpackage

/* hdl/skf_divider.sv */
module skf_divider #(
  parameter int QUO_BITS = 17
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [skf_pkg::PPRE_W-1:0]  dividend,
  input  logic [skf_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [QUO_BITS-1:0]         quotient
);

  localparam int CNT_W = $clog2(QUO_BITS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QUO_BITS - 1);

  logic                        busy;
  logic                        first;
  logic [CNT_W-1:0]            cnt;
  logic [skf_pkg::DEN_W-1:0]   rem;
  logic [skf_pkg::DEN_W-1:0]   dvsr;
  logic [QUO_BITS-1:0]         quo;
  logic [skf_pkg::DEN_W:0]     trial;
  logic [skf_pkg::DEN_W:0]     trial_sub;
  logic                        ge;

  // first step takes the integer part of the dividend (0 or 1), then one
  // fraction bit per step with a zero shifted in
  assign trial     = first ? {1'b0, rem} : {rem, 1'b0};
  assign ge        = trial >= {1'b0, dvsr};
  assign trial_sub = trial - {1'b0, dvsr};

  assign done     = busy && (cnt == LAST);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= skf_pkg::DEN_W'(dividend);
      dvsr  <= divisor;
      first <= 1'b1;
      quo   <= '0;
    end else if (busy) begin
      rem   <= ge ? trial_sub[skf_pkg::DEN_W-1:0] : trial[skf_pkg::DEN_W-1:0];
      first <= 1'b0;
      quo   <= {quo[QUO_BITS-2:0], ge};
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("divider still busy after last step");
  assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("divider became busy without start");

endmodule

/* hdl/skf_mul.sv */
module skf_mul #(
  parameter int A_W = 18,
  parameter int B_W = 34
) (
  input  logic                        clk,
  input  logic signed [A_W-1:0]       op_a,
  input  logic signed [B_W-1:0]       op_b,
  output logic signed [A_W+B_W-1:0]   prod
);

  // single shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

/* hdl/scalar_kalman_filter.sv */
// The gain divider is radix-2 and runs FRAC_BITS+1 steps, then one shared multiplier
// is used twice. s_tready is low while a sample is in work.
// Reset (rst, synchronous): estimate and covariance cleared, Q = 655, R = 65536.
module scalar_kalman_filter #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((skf_pkg::EST_W+FRAC_BITS+1+7)/8)*8-1:0] m_tdata,  // estimate, gain
  input  logic                                  cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [skf_pkg::NOISE_W-1:0]           cfg_data
);

  localparam int G_W    = FRAC_BITS + 1;
  localparam int A_W    = FRAC_BITS + 2;
  localparam int PROD_W = A_W + skf_pkg::MULB_W;
  localparam int OUT_W  = ((skf_pkg::EST_W + G_W + 7) / 8) * 8;
  localparam int TW     = (SAMPLE_BITS + FRAC_BITS > 33) ? SAMPLE_BITS + FRAC_BITS : 33;
  localparam logic [G_W-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [skf_pkg::EST_W-1:0] EST_MAX = 32'sh7fff_ffff;
  localparam logic signed [skf_pkg::EST_W-1:0] EST_MIN = 32'sh8000_0000;

  skf_pkg::state_t state, state_next;

  logic signed [skf_pkg::EST_W-1:0]    est;
  logic [skf_pkg::COV_W-1:0]           cov;
  logic [skf_pkg::NOISE_W-1:0]         q_noise;
  logic [skf_pkg::NOISE_W-1:0]         r_noise;
  logic [skf_pkg::PPRE_W-1:0]          p_pre;
  logic signed [skf_pkg::EST_W-1:0]    target;
  logic                                den_zero;
  logic signed [skf_pkg::EST_W-1:0]    m_est;
  logic [G_W-1:0]                      m_gain;

  logic signed [SAMPLE_BITS-1:0]       sample;
  logic signed [TW-1:0]                tgt_wide;
  logic signed [skf_pkg::EST_W-1:0]    tgt_sat;
  logic [skf_pkg::DEN_W-1:0]           den;
  logic                                div_start;
  logic                                div_done;
  logic [G_W-1:0]                      quo;
  logic [G_W-1:0]                      gain;
  logic signed [skf_pkg::MULB_W-1:0]   diff;
  logic signed [A_W-1:0]               mul_a;
  logic signed [skf_pkg::MULB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]            prod;
  logic signed [skf_pkg::UPD_W-1:0]    upd;
  logic signed [skf_pkg::UPD_W-1:0]    est_sum;
  logic signed [skf_pkg::EST_W-1:0]    est_sat;
  logic [skf_pkg::COV_W-1:0]           cov_sat;
  logic                                in_acc;
  logic                                out_free;

  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // sample << FRAC_BITS, saturated to 32 bits
  assign sample   = s_tdata[SAMPLE_BITS-1:0];
  assign tgt_wide = TW'($signed({sample, {FRAC_BITS{1'b0}}}));
  always_comb begin
    if ((&tgt_wide[TW-1:skf_pkg::EST_W-1]) || !(|tgt_wide[TW-1:skf_pkg::EST_W-1])) begin
      tgt_sat = tgt_wide[skf_pkg::EST_W-1:0];
    end else begin
      tgt_sat = tgt_wide[TW-1] ? EST_MIN : EST_MAX;
    end
  end

  assign den  = skf_pkg::DEN_W'(p_pre) + skf_pkg::DEN_W'(r_noise);
  // all-zero denominator: gain forced to zero
  assign gain = den_zero ? '0 : quo;
  assign diff = skf_pkg::MULB_W'(target) - skf_pkg::MULB_W'(est);

  // floor shift of the product
  assign upd     = prod[FRAC_BITS +: skf_pkg::UPD_W];
  assign est_sum = skf_pkg::UPD_W'(est) + upd;
  always_comb begin
    if ((&est_sum[skf_pkg::UPD_W-1:skf_pkg::EST_W-1]) ||
        !(|est_sum[skf_pkg::UPD_W-1:skf_pkg::EST_W-1])) begin
      est_sat = est_sum[skf_pkg::EST_W-1:0];
    end else begin
      est_sat = est_sum[skf_pkg::UPD_W-1] ? EST_MIN : EST_MAX;
    end
  end
  assign cov_sat = (|upd[skf_pkg::UPD_W-1:skf_pkg::COV_W]) ? '1 : upd[skf_pkg::COV_W-1:0];

  skf_divider #(
    .QUO_BITS (G_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (p_pre),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  skf_mul #(
    .A_W (A_W),
    .B_W (skf_pkg::MULB_W)
  ) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      skf_pkg::S_IDLE:    if (in_acc) state_next = skf_pkg::S_DEN;
      skf_pkg::S_DEN:     state_next = skf_pkg::S_DIV;
      skf_pkg::S_DIV:     if (div_done) state_next = skf_pkg::S_MUL_EST;
      skf_pkg::S_MUL_EST: state_next = skf_pkg::S_MUL_COV;
      skf_pkg::S_MUL_COV: state_next = skf_pkg::S_COV_WB;
      skf_pkg::S_COV_WB:  state_next = skf_pkg::S_OUT;
      skf_pkg::S_OUT:     if (out_free) state_next = skf_pkg::S_IDLE;
      default:            state_next = skf_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    mul_a     = $signed({1'b0, GAIN_ONE - gain});
    mul_b     = $signed({1'b0, p_pre});
    unique case (state)
      skf_pkg::S_IDLE:    s_tready = 1'b1;
      skf_pkg::S_DEN:     div_start = 1'b1;
      skf_pkg::S_MUL_EST: begin
        mul_a = $signed({1'b0, gain});
        mul_b = diff;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise <= skf_pkg::Q_RESET;
      r_noise <= skf_pkg::R_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        skf_pkg::CFG_PROCESS_NOISE:     q_noise <= cfg_data;
        skf_pkg::CFG_MEASUREMENT_NOISE: r_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
      cov <= '0;
    end else begin
      if (state == skf_pkg::S_MUL_COV) begin
        est <= est_sat;
      end
      if (state == skf_pkg::S_COV_WB) begin
        cov <= cov_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_pre  <= skf_pkg::PPRE_W'(cov) + skf_pkg::PPRE_W'(q_noise);
      target <= tgt_sat;
    end
    if (state == skf_pkg::S_DEN) begin
      den_zero <= (den == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == skf_pkg::S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == skf_pkg::S_OUT && out_free) begin
      m_est  <= est;
      m_gain <= gain;
    end
  end

  assign m_tdata = OUT_W'({m_gain, m_est});

  assert property (@(posedge clk) disable iff (rst) in_acc |=> state == skf_pkg::S_DEN)
    else $error("accepted request did not start the step");
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == skf_pkg::S_DIV)
    else $error("divider finished outside the divide phase");
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == skf_pkg::S_OUT)
    else $error("result shown without passing through output load");
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> m_gain <= GAIN_ONE)
    else $error("gain above one");
  assert property (@(posedge clk) disable iff (rst)
    (state == skf_pkg::S_OUT && out_free && den_zero) |=> m_gain == '0)
    else $error("zero denominator gave nonzero gain");

endmodule

/* sim/skf_checker.sv */
`timescale 1ns / 100ps

module skf_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // sample
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [55:0]                   m_tdata,   // estimate, gain
  input  logic                          cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skf_pkg::NOISE_W-1:0]   cfg_data,
  output int                            err_count,
  output int                            outstanding
);

  typedef struct packed {
    logic signed [skf_pkg::EST_W-1:0] estimate;
    logic [16:0]                      gain;
  } filter_out_t;

  logic [skf_pkg::NOISE_W-1:0]      q_noise;
  logic [skf_pkg::NOISE_W-1:0]      r_noise;
  logic signed [skf_pkg::EST_W-1:0] est_state;
  logic [skf_pkg::COV_W-1:0]        cov_state;
  filter_out_t                      filter_results_q[$];

  function automatic filter_out_t kalman_step(input logic signed [15:0] sample);
    logic [skf_pkg::PPRE_W-1:0] p_pre;
    logic [skf_pkg::DEN_W-1:0]  den;
    logic [63:0]                g;
    logic [63:0]                p_next;
    longint                     target;
    longint                     diff;
    longint                     upd;
    longint                     est_next;
    filter_out_t                res;
    p_pre = {1'b0, cov_state} + {2'b0, q_noise};
    den   = {1'b0, p_pre} + {3'b0, r_noise};
    // zero denominator leaves the gain at zero
    g = '0;
    if (den != '0) g = {15'b0, p_pre, 16'b0} / {30'b0, den};
    if (g > 64'd65536) g = 64'd65536;
    target = longint'(sample) * 65536;
    diff   = target - longint'(est_state);
    // arithmetic shift floors toward minus infinity
    upd      = ($signed(g) * diff) >>> 16;
    est_next = longint'(est_state) + upd;
    if (est_next > 64'sd2147483647) est_next = 64'sd2147483647;
    if (est_next < -64'sd2147483648) est_next = -64'sd2147483648;
    p_next = ((64'd65536 - g) * {31'b0, p_pre}) >> 16;
    if (p_next > 64'hFFFF_FFFF) p_next = 64'hFFFF_FFFF;
    est_state    = est_next[31:0];
    cov_state    = p_next[31:0];
    res.estimate = est_next[31:0];
    res.gain     = g[16:0];
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    filter_out_t                      want;
    logic signed [skf_pkg::EST_W-1:0] got_est;
    logic [16:0]                      got_gain;
    if (rst) begin
      q_noise   = skf_pkg::Q_RESET;
      r_noise   = skf_pkg::R_RESET;
      est_state = '0;
      cov_state = '0;
      err_count = 0;
      filter_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          skf_pkg::CFG_PROCESS_NOISE:     q_noise = cfg_data;
          skf_pkg::CFG_MEASUREMENT_NOISE: r_noise = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) filter_results_q.push_back(kalman_step(s_tdata));
      if (m_tvalid && m_tready) begin
        got_est  = m_tdata[31:0];
        got_gain = m_tdata[48:32];
        if (filter_results_q.size() == 0) begin
          $error("result without a pending request: estimate %0d gain %0d",
                 got_est, got_gain);
          err_count++;
        end else begin
          want = filter_results_q.pop_front();
          if (got_est !== want.estimate) begin
            $error("estimate: expected %0d, got %0d", want.estimate, got_est);
            err_count++;
          end
          if (got_gain !== want.gain) begin
            $error("gain: expected %0d, got %0d", want.gain, got_gain);
            err_count++;
          end
        end
      end
    end
    outstanding <= filter_results_q.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int STALL_LIMIT = 3000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [15:0]                   s_tdata = '0;   // sample
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [55:0]                   m_tdata;        // estimate, gain
  logic                          cfg_we = 1'b0;
  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index = skf_pkg::CFG_PROCESS_NOISE;
  logic [skf_pkg::NOISE_W-1:0]   cfg_data = '0;

  int err_count;
  int outstanding;
  int src_idle_pct = 6;
  int sink_idle_pct = 46;
  int stall_cycles = 0;

  scalar_kalman_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  skf_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .err_count   (err_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= (int'($urandom_range(99)) >= sink_idle_pct);
  end

  // run ends if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_sample(input int value);
    while (int'($urandom_range(99)) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value[15:0];
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_noise(input logic [skf_pkg::NOISE_W-1:0] q,
                           input logic [skf_pkg::NOISE_W-1:0] r);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= skf_pkg::CFG_PROCESS_NOISE;
    cfg_data  <= q;
    @(posedge clk);
    cfg_index <= skf_pkg::CFG_MEASUREMENT_NOISE;
    cfg_data  <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [skf_pkg::NOISE_W-1:0] pick_noise();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return skf_pkg::NOISE_W'($urandom_range(4096));
      3:       return skf_pkg::NOISE_W'($urandom_range(1 << 20));
      4:       return skf_pkg::NOISE_W'($urandom_range(1 << 28));
      default: return skf_pkg::NOISE_W'($urandom);
    endcase
  endfunction

  // mostly a steady level plus sensor noise, with outliers and full-range hits
  function automatic int noisy_sample(input int level, input int spread);
    int v;
    case ($urandom_range(19))
      0:       v = -32768;
      1:       v = 32767;
      2, 3:    v = int'($urandom_range(65535)) - 32768;
      default: v = level + int'($urandom_range(2 * spread)) - spread;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  initial begin
    int level;
    int spread;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset noise settings, starting from zero covariance
    send_sample(0);
    send_sample(32767);
    send_sample(-32768);
    send_sample(32767);
    send_sample(-1);
    send_sample(1);
    send_sample(-32768);
    // largest noise values, widest predicted covariance
    set_noise('1, '1);
    send_sample(32767);
    send_sample(-32768);
    send_sample(12345);
    send_sample(-1);
    // no noise: full gain drives covariance to zero, then a zero denominator
    set_noise('0, '0);
    send_sample(100);
    send_sample(-32768);
    send_sample(32767);
    set_noise(skf_pkg::NOISE_W'(1), '0);
    send_sample(5);
    set_noise('0, '1);
    send_sample(-7);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 6;  sink_idle_pct = 46; end
        1: begin src_idle_pct = 46; sink_idle_pct = 6;  end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      for (int chunk = 0; chunk < 4; chunk++) begin
        set_noise(pick_noise(), pick_noise());
        level  = int'($urandom_range(65535)) - 32768;
        spread = 1 << $urandom_range(12);
        for (int n = 0; n < 50; n++) begin
          if ($urandom_range(24) == 0) level = int'($urandom_range(65535)) - 32768;
          send_sample(noisy_sample(level, spread));
        end
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (err_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
